/* hdl/sde_pkg.sv */
// Shared types, constants and operation codes for the SPH density estimator.
// Used by the controller, the datapath and the top level; no dependencies.
package sde_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int CIDX_W = 24;
  localparam int WORD_W = 32;
  localparam int DENS_W = 48;
  localparam int IN_W   = 120;
  localparam int OUT_W  = 72;

  localparam logic [31:0] SELF_WEIGHT_RESET = 32'd1345205232;
  localparam logic [63:0] INV_PI_Q32        = 64'd1367130551;
  localparam logic [63:0] W21_16_Q30        = 64'd1409286144;
  localparam logic [63:0] ONE30             = 64'h0000_0000_4000_0000;

  localparam logic CFG_KERNEL_SELECT = 1'b0;
  localparam logic CFG_SELF_WEIGHT   = 1'b1;

  localparam logic [3:0] OP_ILS  = 4'd0;
  localparam logic [3:0] OP_T    = 4'd1;
  localparam logic [3:0] OP_U    = 4'd2;
  localparam logic [3:0] OP_N    = 4'd3;
  localparam logic [3:0] OP_PROD = 4'd4;
  localparam logic [3:0] OP_B2   = 4'd5;
  localparam logic [3:0] OP_B4   = 4'd6;
  localparam logic [3:0] OP_T4   = 4'd7;
  localparam logic [3:0] OP_W    = 4'd8;
  localparam logic [3:0] OP_C1   = 4'd9;
  localparam logic [3:0] OP_C2   = 4'd10;
  localparam logic [3:0] OP_C3   = 4'd11;
  localparam logic [3:0] OP_P    = 4'd12;
  localparam logic [3:0] OP_C    = 4'd13;

  typedef struct packed {
    logic       load;
    logic       open;
    logic       div_start;
    logic       mul_start;
    logic [3:0] op;
    logic       sqrt_start;
    logic       w_zero;
    logic       w_self;
    logic       emit;
  } sde_cmd_t;

  typedef struct packed {
    logic run_active;
    logic last;
    logic kernel_select;
    logic beyond;
    logic self_hit;
    logic q2_small;
    logic div_done;
    logic mul_done;
    logic mul_busy;
    logic sqrt_done;
    logic out_free;
  } sde_status_t;

endpackage

/* hdl/sde_mul.sv */
// Shared 64 by 64 multiplier built from one 32 by 32 multiplier over four passes.
// Shifts the 128-bit product right and saturates to 64 bits. Uses sde_pkg.
module sde_mul import sde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [6:0]  shift,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  localparam logic [2:0] PASSES   = 3'd4;
  localparam logic [2:0] LAST_CNT = 3'd5;

  logic [2:0]   cnt;
  logic         pp_vld;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [6:0]   s_r;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [1:0]   op_sh;
  logic [127:0] pp_ext;
  logic [127:0] shifted;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        op_a = a_r[31:0];  op_b = b_r[31:0];  op_sh = 2'd0;
      end
      2'd1: begin
        op_a = a_r[63:32]; op_b = b_r[31:0];  op_sh = 2'd1;
      end
      2'd2: begin
        op_a = a_r[31:0];  op_b = b_r[63:32]; op_sh = 2'd1;
      end
      default: begin
        op_a = a_r[63:32]; op_b = b_r[63:32]; op_sh = 2'd2;
      end
    endcase
  end

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
  end

  assign shifted = acc >> s_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      cnt    <= 3'd0;
      pp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 3'd0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        cnt    <= cnt + 3'd1;
        pp_vld <= (cnt < PASSES);
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      s_r <= shift;
      acc <= 128'd0;
    end else if (busy) begin
      if (cnt < PASSES) begin
        pp    <= op_a * op_b;
        pp_sh <= op_sh;
      end
      if (pp_vld) begin
        acc <= acc + pp_ext;
      end
      if (cnt == LAST_CNT) begin
        result <= (|shifted[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0];
      end
    end
  end

endmodule

/* hdl/sde_root.sv */
// Integer square root of a 64-bit value, one result bit per cycle.
// Gives the floor of the root. Uses sde_pkg.
module sde_root import sde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  localparam logic [4:0] LAST_CNT = 5'd31;

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] x;
  logic [33:0] rem;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_sub;

  assign rem_sh  = {rem, x[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= 34'd0;
      root <= 32'd0;
    end else if (busy) begin
      x    <= {x[61:0], 2'b00};
      rem  <= rem_sub[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

/* hdl/sde_ctrl.sv */
// Controller state machine of the density estimator: sequences the divider,
// multiplier and square root of the datapath. Uses sde_pkg for command types.
module sde_ctrl import sde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sde_status_t status,
  output sde_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIV  = 5'd1;
  localparam logic [4:0] S_ILS  = 5'd2;
  localparam logic [4:0] S_T    = 5'd3;
  localparam logic [4:0] S_U    = 5'd4;
  localparam logic [4:0] S_N    = 5'd5;
  localparam logic [4:0] S_PROD = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_SQRT = 5'd8;
  localparam logic [4:0] S_B2   = 5'd9;
  localparam logic [4:0] S_B4   = 5'd10;
  localparam logic [4:0] S_T4   = 5'd11;
  localparam logic [4:0] S_W    = 5'd12;
  localparam logic [4:0] S_C1   = 5'd13;
  localparam logic [4:0] S_C2   = 5'd14;
  localparam logic [4:0] S_C3   = 5'd15;
  localparam logic [4:0] S_P    = 5'd16;
  localparam logic [4:0] S_C    = 5'd17;
  localparam logic [4:0] S_EMIT = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       fresh;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = status.run_active ? S_PROD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = fresh;
        cmd.open      = fresh;
        if (status.div_done) state_next = S_ILS;
      end
      S_ILS: begin
        cmd.op = OP_ILS; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_T;
      end
      S_T: begin
        cmd.op = OP_T; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_U;
      end
      S_U: begin
        cmd.op = OP_U; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_N;
      end
      S_N: begin
        cmd.op = OP_N; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_PROD;
      end
      S_PROD: begin
        cmd.op = OP_PROD; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_CHK;
      end
      S_CHK: begin
        if (status.beyond) begin
          cmd.w_zero = 1'b1;
          state_next = S_P;
        end else if (status.self_hit) begin
          cmd.w_self = 1'b1;
          state_next = S_P;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_start = fresh;
        if (status.sqrt_done) begin
          if (status.kernel_select) state_next = S_B2;
          else if (status.q2_small) state_next = S_C1;
          else state_next = S_C2;
        end
      end
      S_B2: begin
        cmd.op = OP_B2; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_B4;
      end
      S_B4: begin
        cmd.op = OP_B4; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_T4;
      end
      S_T4: begin
        cmd.op = OP_T4; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_W;
      end
      S_W: begin
        cmd.op = OP_W; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_P;
      end
      S_C1: begin
        cmd.op = OP_C1; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_P;
      end
      S_C2: begin
        cmd.op = OP_C2; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_C3;
      end
      S_C3: begin
        cmd.op = OP_C3; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_P;
      end
      S_P: begin
        cmd.op = OP_P; cmd.mul_start = fresh;
        if (status.mul_done) state_next = S_C;
      end
      S_C: begin
        cmd.op = OP_C; cmd.mul_start = fresh;
        if (status.mul_done) state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
    end
  end

endmodule

/* hdl/sde_datapath.sv */
// Datapath of the density estimator: item and run registers, reciprocal divider,
// operand selection for the shared multiplier and square root, output register.
// Uses sde_pkg, sde_mul and sde_root.
module sde_datapath import sde_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  input  logic [IN_W-1:0]    in_data,
  input  logic               in_last,
  input  sde_cmd_t           cmd,
  output sde_status_t        status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_data,
  output logic               out_user
);

  localparam int QW    = 33 + FRAC_BITS;
  localparam int DCW   = $clog2(QW);
  localparam int FB2   = 2 * FRAC_BITS;
  localparam int Q_SHR = (FB2 >= 30) ? (FB2 - 30) : 0;
  localparam int Q_SHL = (FB2 >= 30) ? 0 : (30 - FB2);
  localparam logic [6:0]  SH_ILS = 7'(64 - FRAC_BITS);
  localparam logic [6:0]  SH_F   = 7'(FRAC_BITS);
  localparam logic [63:0] Q2_LIMIT = 64'd4 << FB2;

  logic              ksel;
  logic [31:0]       self_w;
  logic              run_active;
  logic [CIDX_W-1:0] cidx;
  logic [31:0]       h;
  logic [31:0]       d2;
  logic [31:0]       mass;
  logic              last_r;
  logic [63:0]       ih;
  logic [31:0]       ils;
  logic [DENS_W-1:0] norm;
  logic [DENS_W-1:0] sum;
  logic              ov;
  logic [63:0]       tmp;
  logic [63:0]       prod;
  logic [31:0]       w;

  logic              div_busy;
  logic              div_done;
  logic [DCW-1:0]    div_cnt;
  logic [31:0]       div_rem;
  logic [QW-1:0]     div_q;
  logic [32:0]       rem_sh;
  logic              div_ge;
  logic [32:0]       rem_new;
  logic [QW-1:0]     q_next;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [6:0]  mul_s;
  logic        mul_busy;
  logic        mul_done;
  logic [63:0] mul_res;

  logic        sqrt_done;
  logic [31:0] root;
  logic [63:0] q2_wide;
  logic [32:0] q2;
  logic [63:0] radicand;
  logic [31:0] b_val;
  logic [31:0] s_val;
  logic [63:0] three_s;
  logic [63:0] wfac;
  logic [DENS_W:0] sum_add;

  assign rem_sh  = {div_rem, (div_cnt == DCW'(QW - 1))};
  assign div_ge  = (rem_sh >= {1'b0, h});
  assign rem_new = div_ge ? (rem_sh - {1'b0, h}) : rem_sh;
  assign q_next  = {div_q[QW-2:0], div_ge};

  assign q2_wide  = (prod >> Q_SHR) << Q_SHL;
  assign q2       = q2_wide[32:0];
  assign radicand = ksel ? ({31'd0, q2} << 28) : ({31'd0, q2} << 30);
  assign b_val    = (root >= 32'h4000_0000) ? 32'd0 : (32'h4000_0000 - root);
  assign s_val    = (root >= 32'h8000_0000) ? 32'd0 : (32'h8000_0000 - root);
  assign three_s  = ({32'd0, s_val} << 1) + {32'd0, s_val};
  assign wfac     = ONE30 + ({32'd0, root} << 2);
  assign sum_add  = {1'b0, sum} + {1'b0, mul_res[DENS_W-1:0]};

  always_comb begin
    case (cmd.op)
      OP_ILS:  begin mul_a = ih;               mul_b = ih;               mul_s = SH_ILS; end
      OP_T:    begin mul_a = ih;               mul_b = ih;               mul_s = 7'd32;  end
      OP_U:    begin mul_a = tmp;              mul_b = ih;               mul_s = 7'd40;  end
      OP_N:    begin mul_a = tmp;              mul_b = INV_PI_Q32;       mul_s = 7'd32;  end
      OP_PROD: begin mul_a = {32'd0, d2};      mul_b = {32'd0, ils};     mul_s = 7'd0;   end
      OP_B2:   begin mul_a = {32'd0, b_val};   mul_b = {32'd0, b_val};   mul_s = 7'd30;  end
      OP_B4:   begin mul_a = tmp;              mul_b = tmp;              mul_s = 7'd30;  end
      OP_T4:   begin mul_a = tmp;              mul_b = wfac;             mul_s = 7'd30;  end
      OP_W:    begin mul_a = tmp;              mul_b = W21_16_Q30;       mul_s = 7'd30;  end
      OP_C1:   begin mul_a = three_s;          mul_b = {31'd0, q2};      mul_s = 7'd32;  end
      OP_C2:   begin mul_a = {32'd0, s_val};   mul_b = {32'd0, s_val};   mul_s = 7'd30;  end
      OP_C3:   begin mul_a = tmp;              mul_b = {32'd0, s_val};   mul_s = 7'd32;  end
      OP_P:    begin mul_a = {32'd0, w};       mul_b = {16'd0, norm};    mul_s = 7'd30;  end
      OP_C:    begin mul_a = tmp;              mul_b = {32'd0, mass};    mul_s = SH_F;   end
      default: begin mul_a = 64'd0;            mul_b = 64'd0;            mul_s = 7'd0;   end
    endcase
  end

  sde_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .shift  (mul_s),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  sde_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ksel       <= 1'b0;
      self_w     <= SELF_WEIGHT_RESET;
      run_active <= 1'b0;
      out_valid  <= 1'b0;
      div_busy   <= 1'b0;
      div_done   <= 1'b0;
      div_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KERNEL_SELECT: ksel   <= cfg_data[0];
          CFG_SELF_WEIGHT:   self_w <= cfg_data;
          default: ;
        endcase
      end
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= DCW'(QW - 1);
      end else if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
      if (cmd.open) begin
        run_active <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        run_active <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cidx   <= in_data[23:0];
      h      <= in_data[55:24];
      d2     <= in_data[87:56];
      mass   <= in_data[119:88];
      last_r <= in_last;
    end
    if (cmd.div_start) begin
      div_rem <= 32'd0;
      div_q   <= '0;
    end else if (div_busy) begin
      div_rem <= rem_new[31:0];
      div_q   <= q_next;
      if (div_cnt == '0) begin
        ih <= (h == 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : {{(64 - QW){1'b0}}, q_next};
      end
    end
    if (cmd.open) begin
      sum <= '0;
      ov  <= 1'b0;
    end
    if (cmd.w_zero) w <= 32'd0;
    if (cmd.w_self) w <= self_w;
    if (mul_done) begin
      case (cmd.op)
        OP_ILS:  ils  <= (|mul_res[63:32]) ? 32'hFFFF_FFFF : mul_res[31:0];
        OP_T, OP_B2, OP_B4, OP_T4, OP_C2, OP_P: tmp <= mul_res;
        OP_U:    tmp  <= (&tmp) ? tmp : mul_res;
        OP_N:    norm <= ((&tmp) || (|mul_res[63:48])) ? {DENS_W{1'b1}}
                                                      : mul_res[DENS_W-1:0];
        OP_PROD: prod <= mul_res;
        OP_W, OP_C3: w <= mul_res[31:0];
        OP_C1:   w    <= 32'h4000_0000 - mul_res[31:0];
        OP_C: begin
          if ((|mul_res[63:48]) || sum_add[DENS_W]) begin
            sum <= {DENS_W{1'b1}};
            ov  <= 1'b1;
          end else begin
            sum <= sum_add[DENS_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_data <= {sum, cidx};
      out_user <= ov;
    end
  end

  always_comb begin
    status.run_active    = run_active;
    status.last          = last_r;
    status.kernel_select = ksel;
    status.beyond        = (prod > Q2_LIMIT);
    status.self_hit      = ksel && (prod == 64'd0);
    status.q2_small      = (q2 < 33'h0_4000_0000);
    status.div_done      = div_done;
    status.mul_done      = mul_done;
    status.mul_busy      = mul_busy;
    status.sqrt_done     = sqrt_done;
    status.out_free      = !out_valid || out_ready;
  end

endmodule

/* hdl/sph_density_estimate_core.sv */
// SPH density estimator, top level: joins the controller and the datapath.
// Depends on sde_pkg, sde_ctrl and sde_datapath (with sde_mul and sde_root).
//
// Neighbour items arrive on the s_ channel, one run per centre particle; s_tlast
// marks the final neighbour. The first item of a run also supplies the smoothing
// length. One transfer leaves on the m_ channel per run, after the last item.
// Items are worked on one at a time, sequenced over a shared multiplier and a
// square root. An item outside the kernel skips the square root and the kernel
// products, and the cubic spline needs fewer products than the Wendland kernel;
// the first item of a run adds the reciprocal divider and four products. After
// the last item the density is loaded into the output register once it is free.
// A result waiting in the output register does not block work on the next run;
// only the next result waits for it to drain. Configuration writes are taken
// at any edge with cfg_we high and are meant for idle periods. Reset clears the
// run state, the output valid and the registers to their defaults.
module sph_density_estimate_core import sde_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // center_index, smoothing_length, distance_sq, neighbour_mass
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // particle_index, density
  output logic [OUT_W-1:0]  m_tdata,
  // saturated
  output logic              m_tuser
);

  sde_cmd_t    cmd;
  sde_status_t status;

  sde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sde_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Input accepted again while an item is being worked on.");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("Result loaded over one that has not been transferred.");

  a_mul_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !status.mul_busy)
    else $error("Multiplier started while still busy.");

  a_emit_closes_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (m_tvalid && !status.run_active))
    else $error("Result emitted without closing the run.");
`endif

endmodule
